// ===== hw/rtl/spectral_shade_shape_operator_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef SPECTRAL_SHADE_SHAPE_OPERATOR_UNIT_ASSERT_SVH
`define SPECTRAL_SHADE_SHAPE_OPERATOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SSSO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssso check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define SSSO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssso check failed");

`endif

// ===== hw/rtl/ssso_pkg.sv =====
package ssso_pkg;

    // fixed formats: factor Q2.15 signed, its magnitude, sine entries unsigned Q0.15
    localparam int unsigned FAC_BITS      = 18;
    localparam int unsigned UD_BITS       = 17;
    localparam int unsigned SINE_BITS     = 15;
    localparam int unsigned CFG_ADDR_BITS = 5;

    // pi/2 in Q2.30
    localparam logic [63:0] PIBY2 = 64'd1686629713;

    // taylor series divisors for the sine table build
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // register indexes
    typedef enum logic [2:0] {
        REG_MODE,
        REG_SIN_SLANT,
        REG_COS_TILT,
        REG_SIN_TILT,
        REG_LIMIT,
        REG_LOG2_WIDTH,
        REG_LOG2_HEIGHT
    } t_reg_idx;

    typedef struct packed {
        logic                  mode;
        logic [14:0]           sin_slant;
        logic signed [15:0]    cos_tilt;
        logic signed [15:0]    sin_tilt;
        logic [14:0]           limit;
        logic [3:0]            log2_width;
        logic [3:0]            log2_height;
    } t_cfg;

    // classification handed from front to back
    typedef struct packed {
        logic                       mode;
        logic                       zdiv;
        logic signed [FAC_BITS-1:0] fac;
    } t_cls;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_sat;

    // one quarter-wave sine entry, built at elaboration
    function automatic logic [SINE_BITS-1:0] f_sine_entry(input int unsigned k,
                                                          input int unsigned max_log2);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] q30;
        int          i;
        q30 = 64'd1 << 30;
        x   = (64'(k) * PIBY2 + ((64'd1 << (max_log2 - 2)) >> 1)) >> (max_log2 - 2);
        x2  = (x * x) >> 30;
        t   = q30;
        for (i = 0; i < 6; i++) begin
            t = q30 - ((x2 * t) >> 30) / TAYLOR_DIV[i];
        end
        v = (((x * t) >> 30) + (64'd1 << 14)) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_BITS-1:0];
    endfunction

    // clip to the signed 32-bit range
    function automatic t_sat f_sat32(input logic signed [63:0] v);
        t_sat r;
        if (v > 64'sd2147483647) begin
            r.val = 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end else if (v < -64'sd2147483648) begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/spectral_shade_shape_operator_unit.sv =====
// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_stall    | i_in_re, i_in_im, i_col, i_row
// out      | output    | o_out_valid / i_out_stall  | o_out_re, o_out_im, o_saturated,
//          |           |                            | o_zero_divisor
// config   | apb       | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// one item per cycle sustained while no stall holds the flow; items pass 5 front stages,
// one queue slot and the bit-per-stage divider stages in the back end
// reset (i_rst_n low, synchronous) clears valids, queue and config registers
// a stalled output halts only the back end; the front keeps taking items
// until the 4-entry queue fills, then raises o_in_stall
module spectral_shade_shape_operator_unit
    import ssso_pkg::*;
#(
    parameter int unsigned MAX_LOG2_SIZE = 10,
    parameter int unsigned DATA_BITS     = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [DATA_BITS-1:0] i_in_re,
    input  logic signed [DATA_BITS-1:0] i_in_im,
    input  logic [9:0]                  i_col,
    input  logic [9:0]                  i_row,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_out_re,
    output logic signed [31:0]          o_out_im,
    output logic                        o_saturated,
    output logic                        o_zero_divisor,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [CFG_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned QW = 2 + FAC_BITS + 2 * DATA_BITS;

    t_cfg                        r_cfg;
    t_reg_idx                    w_idx;
    logic                        w_push;
    logic                        w_pop;
    logic                        w_full;
    logic                        w_empty;
    t_cls                        w_f_cls;
    t_cls                        w_b_cls;
    logic signed [DATA_BITS-1:0] w_f_re;
    logic signed [DATA_BITS-1:0] w_f_im;
    logic signed [DATA_BITS-1:0] w_b_re;
    logic signed [DATA_BITS-1:0] w_b_im;
    logic [QW-1:0]               w_q_out;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    // register write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= 1'b0;
            r_cfg.sin_slant   <= 15'd32767;
            r_cfg.cos_tilt    <= 16'sd32767;
            r_cfg.sin_tilt    <= 16'sd0;
            r_cfg.limit       <= 15'd3277;
            r_cfg.log2_width  <= 4'd8;
            r_cfg.log2_height <= 4'd8;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_MODE:        r_cfg.mode        <= pwdata[0];
                REG_SIN_SLANT:   r_cfg.sin_slant   <= pwdata[14:0];
                REG_COS_TILT:    r_cfg.cos_tilt    <= pwdata[15:0];
                REG_SIN_TILT:    r_cfg.sin_tilt    <= pwdata[15:0];
                REG_LIMIT:       r_cfg.limit       <= pwdata[14:0];
                REG_LOG2_WIDTH:  r_cfg.log2_width  <= pwdata[3:0];
                REG_LOG2_HEIGHT: r_cfg.log2_height <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (w_idx)
            REG_MODE:        prdata = 32'(r_cfg.mode);
            REG_SIN_SLANT:   prdata = 32'(r_cfg.sin_slant);
            REG_COS_TILT:    prdata = 32'(r_cfg.cos_tilt[15:0]);
            REG_SIN_TILT:    prdata = 32'(r_cfg.sin_tilt[15:0]);
            REG_LIMIT:       prdata = 32'(r_cfg.limit);
            REG_LOG2_WIDTH:  prdata = 32'(r_cfg.log2_width);
            REG_LOG2_HEIGHT: prdata = 32'(r_cfg.log2_height);
            default:         prdata = '0;
        endcase
    end

    // front: accept, sine lookup, factor and its class
    ssso_front #(
        .MAX_LOG2_SIZE(MAX_LOG2_SIZE),
        .DATA_BITS    (DATA_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_re   (i_in_re),
        .i_in_im   (i_in_im),
        .i_col     (i_col),
        .i_row     (i_row),
        .o_push    (w_push),
        .o_cls     (w_f_cls),
        .o_re      (w_f_re),
        .o_im      (w_f_im),
        .i_full    (w_full)
    );

    // queue between the two halves
    ssso_queue #(
        .WIDTH(QW),
        .DEPTH(4)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_f_cls, w_f_re, w_f_im}),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_data (w_q_out),
        .o_empty(w_empty)
    );

    assign w_b_cls = w_q_out[QW-1 -: (2 + FAC_BITS)];
    assign w_b_re  = w_q_out[2*DATA_BITS-1 -: DATA_BITS];
    assign w_b_im  = w_q_out[DATA_BITS-1:0];

    // back: multiply or divide, round, clip
    ssso_back #(
        .DATA_BITS(DATA_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .i_cls         (w_b_cls),
        .i_re          (w_b_re),
        .i_im          (w_b_im),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_re      (o_out_re),
        .o_out_im      (o_out_im),
        .o_saturated   (o_saturated),
        .o_zero_divisor(o_zero_divisor)
    );

endmodule

// ===== hw/rtl/ssso_front.sv =====
module ssso_front
    import ssso_pkg::*;
#(
    parameter int unsigned MAX_LOG2_SIZE = 10,
    parameter int unsigned DATA_BITS     = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [DATA_BITS-1:0] i_in_re,
    input  logic signed [DATA_BITS-1:0] i_in_im,
    input  logic [9:0]                  i_col,
    input  logic [9:0]                  i_row,
    output logic                        o_push,
    output t_cls                        o_cls,
    output logic signed [DATA_BITS-1:0] o_re,
    output logic signed [DATA_BITS-1:0] o_im,
    input  logic                        i_full
);

    localparam int unsigned TWOPI   = 1 << MAX_LOG2_SIZE;
    localparam int unsigned QUARTER = TWOPI / 4;
    localparam int unsigned IW      = MAX_LOG2_SIZE - 1;
    localparam int unsigned PW      = MAX_LOG2_SIZE + 10;
    localparam int unsigned NSTG    = 5;

    // quarter-wave sine table
    logic [SINE_BITS-1:0] w_rom [QUARTER+1];
    for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
        assign w_rom[k] = f_sine_entry(k, MAX_LOG2_SIZE);
    end

    // phase of a position: scale up to a full turn of TWOPI units
    function automatic logic [MAX_LOG2_SIZE-1:0] f_phase(input logic [9:0] pos,
                                                         input logic [3:0] lg);
        logic [3:0]    lg_eff;
        logic [PW-1:0] w;
        lg_eff = (lg > 4'(MAX_LOG2_SIZE)) ? 4'(MAX_LOG2_SIZE) : lg;
        w      = PW'(pos) << (4'(MAX_LOG2_SIZE) - lg_eff);
        return w[MAX_LOG2_SIZE-1:0];
    endfunction

    // table index from phase, mirrored in odd quadrants
    function automatic logic [IW-1:0] f_rom_idx(input logic [MAX_LOG2_SIZE-1:0] p);
        logic [IW-1:0] off;
        off = IW'(p) & IW'(QUARTER - 1);
        return p[MAX_LOG2_SIZE-2] ? (IW'(QUARTER) - off) : off;
    endfunction

    logic                        w_adv;
    logic [MAX_LOG2_SIZE-1:0]    w_px;
    logic [MAX_LOG2_SIZE-1:0]    w_py;
    logic signed [15:0]          w_sx;
    logic signed [15:0]          w_sy;
    logic signed [48:0]          w_rnd;
    logic signed [FAC_BITS-1:0]  w_fac;
    logic signed [FAC_BITS-1:0]  w_lim;
    t_cls                        w_cls;

    logic [NSTG:1]               r_v;
    logic signed [DATA_BITS-1:0] r_re [NSTG:1];
    logic signed [DATA_BITS-1:0] r_im [NSTG:1];
    logic signed [15:0]          r_sx;
    logic signed [15:0]          r_sy;
    logic signed [31:0]          r_p1;
    logic signed [31:0]          r_p2;
    logic signed [32:0]          r_sum;
    logic signed [48:0]          r_prod;
    logic [14:0]                 r_lim;
    t_cls                        r_cls;

    // front moves unless its last stage waits on a full queue
    assign w_adv      = !(r_v[NSTG] && i_full);
    assign o_in_stall = !w_adv;
    assign o_push     = r_v[NSTG] && !i_full;
    assign o_cls      = r_cls;
    assign o_re       = r_re[NSTG];
    assign o_im       = r_im[NSTG];

    // sine lookups for column and row
    always_comb begin
        w_px = f_phase(i_col, i_cfg.log2_width);
        w_py = f_phase(i_row, i_cfg.log2_height);
        w_sx = w_px[MAX_LOG2_SIZE-1] ? -$signed({1'b0, w_rom[f_rom_idx(w_px)]})
                                     :  $signed({1'b0, w_rom[f_rom_idx(w_px)]});
        w_sy = w_py[MAX_LOG2_SIZE-1] ? -$signed({1'b0, w_rom[f_rom_idx(w_py)]})
                                     :  $signed({1'b0, w_rom[f_rom_idx(w_py)]});
    end

    // round the factor and push it away from zero in shape mode
    always_comb begin
        w_rnd = (r_prod + (49'sd1 <<< 29)) >>> 30;
        w_fac = w_rnd[FAC_BITS-1:0];
        w_lim = $signed({3'b000, r_lim});
        w_cls.mode = i_cfg.mode;
        w_cls.fac  = w_fac;
        if (i_cfg.mode) begin
            if (w_fac > 0) begin
                if (w_fac < w_lim) begin
                    w_cls.fac = w_lim;
                end
            end else if (w_fac > -w_lim) begin
                w_cls.fac = -w_lim;
            end
        end
        w_cls.zdiv = i_cfg.mode && (w_cls.fac == '0);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NSTG-1:1], i_in_valid};
        end
    end

    // shade floor, follows config
    always_ff @(posedge i_clk) begin
        r_lim <= 15'((30'(i_cfg.limit) * 30'(i_cfg.sin_slant) + 30'd16384) >> 15);
    end

    // factor pipeline
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_re[1] <= i_in_re;
            r_im[1] <= i_in_im;
            for (int s = 2; s <= NSTG; s++) begin
                r_re[s] <= r_re[s-1];
                r_im[s] <= r_im[s-1];
            end
            r_sx   <= w_sx;
            r_sy   <= w_sy;
            r_p1   <= r_sx * i_cfg.cos_tilt;
            r_p2   <= r_sy * i_cfg.sin_tilt;
            r_sum  <= 33'(r_p1) + 33'(r_p2);
            r_prod <= 49'(r_sum) * 49'($signed({1'b0, i_cfg.sin_slant}));
            r_cls  <= w_cls;
        end
    end

endmodule

// ===== hw/rtl/ssso_queue.sv =====
module ssso_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/ssso_back.sv =====
module ssso_back
    import ssso_pkg::*;
#(
    parameter int unsigned DATA_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  t_cls                        i_cls,
    input  logic signed [DATA_BITS-1:0] i_re,
    input  logic signed [DATA_BITS-1:0] i_im,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_out_re,
    output logic signed [31:0]          o_out_im,
    output logic                        o_saturated,
    output logic                        o_zero_divisor
);

    localparam int unsigned NW = DATA_BITS + 16;
    localparam int unsigned PW = DATA_BITS + FAC_BITS + 1;

    typedef struct packed {
        logic                 mode;
        logic                 zdiv;
        logic                 neg_re;
        logic                 neg_im;
        logic [UD_BITS-1:0]   ud;
        logic [NW-1:0]        n_re;
        logic [NW-1:0]        n_im;
        logic [NW-1:0]        q_re;
        logic [NW-1:0]        q_im;
        logic [UD_BITS-1:0]   rem_re;
        logic [UD_BITS-1:0]   rem_im;
        logic signed [PW-1:0] pr_re;
        logic signed [PW-1:0] pr_im;
    } t_bst;

    logic                 w_adv;
    t_bst                 w_in;
    t_bst                 w_nxt [NW+1];
    logic [DATA_BITS-1:0] w_abs_re;
    logic [DATA_BITS-1:0] w_abs_im;
    t_sat                 w_sat_re;
    t_sat                 w_sat_im;
    logic signed [PW-1:0] w_rnd_re;
    logic signed [PW-1:0] w_rnd_im;

    t_bst                 r_b  [NW+1];
    logic [NW:0]          r_bv;
    logic                 r_out_valid;
    logic signed [31:0]   r_out_re;
    logic signed [31:0]   r_out_im;
    logic                 r_sat;
    logic                 r_zdiv;

    // back moves unless a result waits to be taken
    assign w_adv          = !(r_out_valid && i_out_stall);
    assign o_pop          = w_adv && !i_empty;
    assign o_out_valid    = r_out_valid;
    assign o_out_re       = r_out_re;
    assign o_out_im       = r_out_im;
    assign o_saturated    = r_sat;
    assign o_zero_divisor = r_zdiv;

    // operand set-up: magnitudes, rounding offset, shade products
    always_comb begin
        w_abs_re      = i_re[DATA_BITS-1] ? DATA_BITS'(-i_re) : DATA_BITS'(i_re);
        w_abs_im      = i_im[DATA_BITS-1] ? DATA_BITS'(-i_im) : DATA_BITS'(i_im);
        w_in.mode     = i_cls.mode;
        w_in.zdiv     = i_cls.zdiv;
        w_in.ud       = i_cls.fac[FAC_BITS-1] ? UD_BITS'(-i_cls.fac) : UD_BITS'(i_cls.fac);
        w_in.n_re     = NW'({w_abs_im, 15'b0}) + NW'(w_in.ud >> 1);
        w_in.n_im     = NW'({w_abs_re, 15'b0}) + NW'(w_in.ud >> 1);
        w_in.neg_re   = (!i_im[DATA_BITS-1] && (i_im != '0)) != i_cls.fac[FAC_BITS-1];
        w_in.neg_im   = i_re[DATA_BITS-1] != i_cls.fac[FAC_BITS-1];
        w_in.q_re     = '0;
        w_in.q_im     = '0;
        w_in.rem_re   = '0;
        w_in.rem_im   = '0;
        w_in.pr_re    = PW'(i_cls.fac) * PW'(i_im);
        w_in.pr_im    = -(PW'(i_cls.fac) * PW'(i_re));
    end

    // one restoring quotient bit per stage for both parts
    always_comb begin
        logic [UD_BITS:0] t_re;
        logic [UD_BITS:0] t_im;
        w_nxt[0] = w_in;
        for (int s = 1; s <= NW; s++) begin
            w_nxt[s] = r_b[s-1];
            t_re = {r_b[s-1].rem_re, r_b[s-1].n_re[NW-1]};
            t_im = {r_b[s-1].rem_im, r_b[s-1].n_im[NW-1]};
            w_nxt[s].n_re = r_b[s-1].n_re << 1;
            w_nxt[s].n_im = r_b[s-1].n_im << 1;
            if (t_re >= {1'b0, r_b[s-1].ud}) begin
                w_nxt[s].rem_re = UD_BITS'(t_re - {1'b0, r_b[s-1].ud});
                w_nxt[s].q_re   = {r_b[s-1].q_re[NW-2:0], 1'b1};
            end else begin
                w_nxt[s].rem_re = t_re[UD_BITS-1:0];
                w_nxt[s].q_re   = {r_b[s-1].q_re[NW-2:0], 1'b0};
            end
            if (t_im >= {1'b0, r_b[s-1].ud}) begin
                w_nxt[s].rem_im = UD_BITS'(t_im - {1'b0, r_b[s-1].ud});
                w_nxt[s].q_im   = {r_b[s-1].q_im[NW-2:0], 1'b1};
            end else begin
                w_nxt[s].rem_im = t_im[UD_BITS-1:0];
                w_nxt[s].q_im   = {r_b[s-1].q_im[NW-2:0], 1'b0};
            end
        end
    end

    // final selection: rounded product or signed quotient, then clip; a zero divisor gives zero
    always_comb begin
        w_rnd_re = (r_b[NW].pr_re + (PW'(1) <<< 14)) >>> 15;
        w_rnd_im = (r_b[NW].pr_im + (PW'(1) <<< 14)) >>> 15;
        if (r_b[NW].mode) begin
            w_sat_re = f_sat32(r_b[NW].neg_re ? -$signed(64'(r_b[NW].q_re))
                                              :  $signed(64'(r_b[NW].q_re)));
            w_sat_im = f_sat32(r_b[NW].neg_im ? -$signed(64'(r_b[NW].q_im))
                                              :  $signed(64'(r_b[NW].q_im)));
        end else begin
            w_sat_re = f_sat32(64'(w_rnd_re));
            w_sat_im = f_sat32(64'(w_rnd_im));
        end
        if (r_b[NW].zdiv) begin
            w_sat_re = '0;
            w_sat_im = '0;
        end
    end

    // stage valid bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_bv        <= {r_bv[NW-1:0], o_pop};
            r_out_valid <= r_bv[NW];
        end
    end

    // stage data and result register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s <= NW; s++) begin
                r_b[s] <= w_nxt[s];
            end
            r_out_re <= w_sat_re.val;
            r_out_im <= w_sat_im.val;
            r_sat    <= w_sat_re.sat | w_sat_im.sat;
            r_zdiv   <= r_b[NW].zdiv;
        end
    end

endmodule

// ===== hw/rtl/ssso_checker.sv =====
`include "spectral_shade_shape_operator_unit_assert.svh"

module ssso_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_out_re,
    input logic [31:0] o_out_im,
    input logic        o_saturated,
    input logic        o_zero_divisor
);

    // a stalled result holds
    `SSSO_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_re) && $stable(o_out_im))

    // zero divisor gives a clean zero result
    `SSSO_ASSERT_IMP(a_zdiv_zero, o_out_valid && o_zero_divisor, o_out_re == 32'd0 && o_out_im == 32'd0 && !o_saturated)

    // a clipped result sits at a range limit
    `SSSO_ASSERT_IMP(a_sat_limit, o_out_valid && o_saturated, o_out_re == 32'h7FFF_FFFF || o_out_re == 32'h8000_0000 || o_out_im == 32'h7FFF_FFFF || o_out_im == 32'h8000_0000)

endmodule

bind spectral_shade_shape_operator_unit ssso_checker u_checker (.*);
